FILE: sv/scm_pkg.sv
// shared constants, item types and controller commands of the cv modulator
package scm_pkg;

  localparam int CV_OUTPUTS  = 4;
  localparam int CV_BITS     = 12;
  localparam int CV_FIELDS   = 4;
  localparam int CV_W        = 12;
  localparam int NUM_WEIGHTS = 4;
  localparam int WEIGHT_W    = 8;
  localparam int SEL_W       = 3;
  localparam int STATE_W     = 8;
  localparam int SUM_W       = WEIGHT_W + $clog2(NUM_WEIGHTS);
  localparam int NUM_W       = SUM_W + CV_BITS;
  localparam int CV_IDX_W    = (CV_FIELDS > 1) ? $clog2(CV_FIELDS) : 1;
  localparam int STEP_W      = (CV_BITS > 1) ? $clog2(CV_BITS) : 1;

  localparam int MAP_W       = NUM_WEIGHTS * SEL_W * CV_FIELDS;
  localparam int WGT_REG_W   = NUM_WEIGHTS * WEIGHT_W;
  localparam int DATA_W      = 64;
  localparam int ADDR_W      = 4;
  localparam int REG_SEL_BIT = 3;

  localparam logic REG_BIT_MAP = 1'b0;
  localparam logic REG_WEIGHTS = 1'b1;

  localparam logic [MAP_W-1:0]     BIT_MAP_RESET = 48'd114927023457928;
  localparam logic [WGT_REG_W-1:0] WEIGHTS_RESET = 32'd134480385;

  localparam logic [CV_BITS-1:0] FULL_SCALE = {CV_BITS{1'b1}};

  typedef struct packed {
    logic clock_level;
    logic clock_pulse;
    logic data1_level;
    logic data2_level;
    logic open_mode;
    logic strobe_level;
  } in_item_t;

  typedef struct packed {
    logic               serial_bit;
    logic               strobe_echo;
    logic [STATE_W-1:0] latched_state;
    logic [CV_W-1:0]    cv_zero;
    logic [CV_W-1:0]    cv_one;
    logic [CV_W-1:0]    cv_two;
    logic [CV_W-1:0]    cv_three;
  } out_item_t;

  typedef struct packed {
    logic                load;
    logic                div_init;
    logic                div_step;
    logic                div_last;
    logic                publish;
    logic [CV_IDX_W-1:0] cv_idx;
  } scm_cmd_t;

endpackage

FILE: sv/shift_register_cv_modulator.sv
// shift register cv modulator top level: config port, controller and datapath
// per cv output the shared serial divider runs a setup step and 12 restoring-division
// steps; all results are then published once the output register is free
// a new item is taken only after the previous one has been published
// a finished result waits in the output register while the next item is taken
// reset (synchronous, active low) clears shift register, latch, clock history,
// handshake state and restores the bit map and weights to their defaults
module shift_register_cv_modulator import scm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [MAP_W-1:0]     bit_map;
  logic [WGT_REG_W-1:0] weights;
  scm_cmd_t             cmd;

  scm_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .bit_map     (bit_map),
    .weights     (weights)
  );

  scm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  scm_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .bit_map  (bit_map),
    .weights  (weights),
    .out_data (out_data)
  );

endmodule

FILE: sv/scm_regs.sv
// configuration registers behind the apb-style port
module scm_regs import scm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [ADDR_W-1:0]    cfg_paddr,
  input  logic [DATA_W-1:0]    cfg_pwdata,
  output logic [DATA_W-1:0]    cfg_prdata,
  output logic                 cfg_pready,
  output logic [MAP_W-1:0]     bit_map,
  output logic [WGT_REG_W-1:0] weights
);

  logic [MAP_W-1:0]     bit_map_r;
  logic [WGT_REG_W-1:0] weights_r;
  logic                 wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_map_r <= BIT_MAP_RESET;
      weights_r <= WEIGHTS_RESET;
    end else if (wr_en) begin
      if (cfg_paddr[REG_SEL_BIT] == REG_WEIGHTS) begin
        weights_r <= cfg_pwdata[WGT_REG_W-1:0];
      end else begin
        bit_map_r <= cfg_pwdata[MAP_W-1:0];
      end
    end
  end

  always_comb begin
    if (cfg_paddr[REG_SEL_BIT] == REG_BIT_MAP) begin
      cfg_prdata = DATA_W'(bit_map_r);
    end else begin
      cfg_prdata = DATA_W'(weights_r);
    end
  end

  assign bit_map = bit_map_r;
  assign weights = weights_r;

endmodule

FILE: sv/scm_ctrl.sv
// controller: item handshake, per-output divider sequencing, result publish
module scm_ctrl import scm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output scm_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_INIT = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_HOLD = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [CV_IDX_W-1:0] cv_idx_r, cv_idx_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt    = state_r;
    cv_idx_nxt   = cv_idx_r;
    step_nxt     = step_r;
    cmd          = '0;
    cmd.cv_idx   = cv_idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          cv_idx_nxt = '0;
          state_nxt  = S_INIT;
        end
      end
      S_INIT: begin
        cmd.div_init = 1'b1;
        step_nxt     = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == STEP_W'(CV_BITS - 1)) begin
          cmd.div_last = 1'b1;
          if (cv_idx_r == CV_IDX_W'(CV_OUTPUTS - 1)) begin
            state_nxt = S_HOLD;
          end else begin
            cv_idx_nxt = cv_idx_r + 1'b1;
            state_nxt  = S_INIT;
          end
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_HOLD: begin
        if (!out_valid_r || out_ready) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cv_idx_r    <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cv_idx_r    <= cv_idx_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: sv/scm_dp.sv
// datapath: shift register, output latch, weighted sums and serial divider
module scm_dp import scm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  in_item_t             in_data,
  input  scm_cmd_t             cmd,
  input  logic [MAP_W-1:0]     bit_map,
  input  logic [WGT_REG_W-1:0] weights,
  output out_item_t            out_data
);

  logic [STATE_W-1:0] shift_r, latch_r;
  logic               prev_clk_r;
  logic               serial_r, strobe_r;
  logic [SUM_W-1:0]   rem_r;
  logic [CV_BITS-1:0] low_r, quo_r;
  logic [CV_W-1:0]    cv_res_r [CV_FIELDS];
  out_item_t          out_r;

  logic               do_shift;
  logic               bit_in;
  logic [STATE_W-1:0] shift_nxt, latch_nxt;
  logic [SUM_W-1:0]   total, sum;
  logic [SEL_W-1:0]   sel;
  logic [NUM_W-1:0]   num;
  logic [SUM_W:0]     trial;
  logic               ge;
  logic [SUM_W-1:0]   rem_nxt;
  logic [CV_BITS-1:0] quo_nxt;
  logic [CV_W-1:0]    cv_final;

  always_comb begin
    do_shift = (in_data.clock_level & ~prev_clk_r) | in_data.clock_pulse;
    if (in_data.open_mode) begin
      bit_in = in_data.data1_level | in_data.data2_level;
    end else begin
      bit_in = (shift_r[STATE_W-1] ^ shift_r[0]) | in_data.data1_level;
    end
    shift_nxt = do_shift ? {shift_r[STATE_W-2:0], bit_in} : shift_r;
    latch_nxt = in_data.strobe_level ? latch_r : shift_nxt;
  end

  always_comb begin
    total = '0;
    sum   = '0;
    sel   = '0;
    for (int w = 0; w < NUM_WEIGHTS; w++) begin
      sel   = bit_map[(int'(cmd.cv_idx) * NUM_WEIGHTS + w) * SEL_W +: SEL_W];
      total = total + SUM_W'(weights[w*WEIGHT_W +: WEIGHT_W]);
      if (latch_r[sel]) begin
        sum = sum + SUM_W'(weights[w*WEIGHT_W +: WEIGHT_W]);
      end
    end
    num = NUM_W'(sum) * NUM_W'(FULL_SCALE) + NUM_W'(total >> 1);
  end

  always_comb begin
    trial   = {rem_r, low_r[CV_BITS-1]};
    ge      = (trial >= {1'b0, total});
    rem_nxt = ge ? SUM_W'(trial - {1'b0, total}) : trial[SUM_W-1:0];
    quo_nxt = {quo_r[CV_BITS-2:0], ge};
    cv_final = (total == '0) ? '0 : CV_W'(quo_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r    <= '0;
      latch_r    <= '0;
      prev_clk_r <= 1'b0;
    end else if (cmd.load) begin
      shift_r    <= shift_nxt;
      latch_r    <= latch_nxt;
      prev_clk_r <= in_data.clock_level;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      serial_r <= do_shift & shift_r[STATE_W-1];
      strobe_r <= in_data.strobe_level;
    end
    if (cmd.div_init) begin
      rem_r <= num[NUM_W-1:CV_BITS];
      low_r <= num[CV_BITS-1:0];
      quo_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      low_r <= {low_r[CV_BITS-2:0], 1'b0};
      quo_r <= quo_nxt;
    end
    if (cmd.div_last) begin
      cv_res_r[cmd.cv_idx] <= cv_final;
    end
    if (cmd.publish) begin
      out_r.serial_bit    <= serial_r;
      out_r.strobe_echo   <= strobe_r;
      out_r.latched_state <= latch_r;
      out_r.cv_zero       <= (0 < CV_OUTPUTS) ? cv_res_r[0] : '0;
      out_r.cv_one        <= (1 < CV_OUTPUTS) ? cv_res_r[1] : '0;
      out_r.cv_two        <= (2 < CV_OUTPUTS) ? cv_res_r[2] : '0;
      out_r.cv_three      <= (3 < CV_OUTPUTS) ? cv_res_r[3] : '0;
    end
  end

  assign out_data = out_r;

endmodule

FILE: sv/scm_checker.sv
// port-level checker for the cv modulator and its bind
module scm_checker import scm_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input in_item_t          in_data,
  input logic              out_valid,
  input logic              out_ready,
  input out_item_t         out_data,
  input logic              cfg_psel,
  input logic              cfg_penable,
  input logic              cfg_pwrite,
  input logic [ADDR_W-1:0] cfg_paddr,
  input logic [DATA_W-1:0] cfg_pwdata,
  input logic [DATA_W-1:0] cfg_prdata,
  input logic              cfg_pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed or dropped while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset did not leave the block idle");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while previous item still in work");

  a_no_result_while_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && in_ready && !in_valid |=> !out_valid)
    else $error("result item without an accepted item");

  a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable |-> cfg_pready)
    else $error("config access stalled");

endmodule

bind shift_register_cv_modulator scm_checker u_scm_checker (.*);

FILE: tb/shift_register_cv_modulator_tb.sv
// testbench for the shift register cv modulator: directed and random gate ticks checked against a scoreboard
`timescale 1ns / 1ps

module shift_register_cv_modulator_tb;
  import scm_pkg::*;

  class cv_scoreboard;
    logic [MAP_W-1:0]     bit_map;
    logic [WGT_REG_W-1:0] weights;
    logic [STATE_W-1:0]   shift_bits;
    logic [STATE_W-1:0]   latch_bits;
    logic                 clock_seen;
    out_item_t            due_outputs[$];
    int unsigned          mismatches;
    int unsigned          lines_left;

    function new();
      bit_map     = BIT_MAP_RESET;
      weights     = WEIGHTS_RESET;
      shift_bits  = '0;
      latch_bits  = '0;
      clock_seen  = 1'b0;
      mismatches  = 0;
      lines_left  = 60;
    endfunction

    function logic [CV_W-1:0] cv_level(int idx);
      int unsigned total;
      int unsigned sum;
      int unsigned wt;
      logic [SEL_W-1:0] sel;
      total = 0;
      sum   = 0;
      if (idx >= CV_OUTPUTS) return '0;
      for (int w = 0; w < NUM_WEIGHTS; w++) begin
        sel = bit_map[NUM_WEIGHTS*SEL_W*idx + SEL_W*w +: SEL_W];
        wt  = 32'(weights[WEIGHT_W*w +: WEIGHT_W]);
        total += wt;
        if (latch_bits[sel]) sum += wt;
      end
      if (total == 0) return '0;
      return CV_W'((sum * int'(FULL_SCALE) + total / 2) / total);
    endfunction

    function void note_tick(in_item_t t);
      logic      fire;
      logic      top_bit;
      logic      new_bit;
      out_item_t r;
      fire = (t.clock_level && !clock_seen) || t.clock_pulse;
      clock_seen = t.clock_level;
      r.serial_bit = 1'b0;
      if (fire) begin
        top_bit = shift_bits[STATE_W-1];
        if (t.open_mode) new_bit = t.data1_level | t.data2_level;
        else new_bit = (top_bit ^ shift_bits[0]) | t.data1_level;
        r.serial_bit = top_bit;
        shift_bits = {shift_bits[STATE_W-2:0], new_bit};
      end
      if (!t.strobe_level) latch_bits = shift_bits;
      r.strobe_echo   = t.strobe_level;
      r.latched_state = latch_bits;
      r.cv_zero       = cv_level(0);
      r.cv_one        = cv_level(1);
      r.cv_two        = cv_level(2);
      r.cv_three      = cv_level(3);
      due_outputs.push_back(r);
    endfunction

    task report(string msg);
      mismatches++;
      if (lines_left > 0) begin
        lines_left--;
        $display("%0t ns: %s", $time, msg);
      end
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (due_outputs.size() == 0) begin
        report("result item with nothing outstanding");
        return;
      end
      want = due_outputs.pop_front();
      check_field("serial_bit", 32'(got.serial_bit), 32'(want.serial_bit));
      check_field("strobe_echo", 32'(got.strobe_echo), 32'(want.strobe_echo));
      check_field("latched_state", 32'(got.latched_state), 32'(want.latched_state));
      check_field("cv_zero", 32'(got.cv_zero), 32'(want.cv_zero));
      check_field("cv_one", 32'(got.cv_one), 32'(want.cv_one));
      check_field("cv_two", 32'(got.cv_two), 32'(want.cv_two));
      check_field("cv_three", 32'(got.cv_three), 32'(want.cv_three));
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_ready;
  out_item_t         out_data;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [DATA_W-1:0] cfg_pwdata;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  cv_scoreboard sb;
  bit           steady_flow;
  bit           long_hold_req;

  shift_register_cv_modulator DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #6000000;
    $display("shift_register_cv_modulator: mismatch");
    $finish;
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 120);
  endfunction

  function automatic in_item_t tick(bit c, bit p, bit d1, bit d2, bit en, bit s);
    in_item_t t;
    t.clock_level  = c;
    t.clock_pulse  = p;
    t.data1_level  = d1;
    t.data2_level  = d2;
    t.open_mode    = en;
    t.strobe_level = s;
    return t;
  endfunction

  function automatic in_item_t random_tick();
    return tick($urandom_range(0, 1), $urandom_range(0, 3) == 0, $urandom_range(0, 1),
                $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 3) == 0);
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (600) @(posedge clk);
      end else begin
        int unsigned stall;
        stall = idle_len();
        if (stall == 0) begin
          out_ready <= 1'b1;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end else begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_tick(in_data);
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  task send_tick(input in_item_t t);
    int unsigned gap;
    in_data  <= t;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task send_random(int unsigned count);
    repeat (count) send_tick(random_tick());
    in_valid <= 1'b0;
  endtask

  task drain_results();
    @(posedge clk);
    while (sb.due_outputs.size() != 0) @(posedge clk);
  endtask

  task write_reg(input logic reg_sel, input logic [DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_W'(reg_sel) << REG_SEL_BIT;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (reg_sel == REG_BIT_MAP) sb.bit_map = value[MAP_W-1:0];
    else sb.weights = value[WGT_REG_W-1:0];
    @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] random_word();
    return {$urandom, $urandom};
  endfunction

  initial begin
    in_item_t directed_q[$];
    sb = new();
    steady_flow   = 1'b0;
    long_hold_req = 1'b0;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // edges, pulses, both bit 0 modes, strobe freeze, then fill with ones
    // so bit 7 leaves as a one and feedback sees bit 7 and bit 0 set
    directed_q.push_back(tick(0, 0, 0, 0, 0, 0));
    directed_q.push_back(tick(1, 0, 1, 0, 1, 0));
    directed_q.push_back(tick(1, 0, 0, 1, 1, 0));
    directed_q.push_back(tick(0, 0, 0, 1, 1, 0));
    directed_q.push_back(tick(0, 1, 0, 1, 1, 0));
    directed_q.push_back(tick(1, 1, 0, 0, 0, 0));
    directed_q.push_back(tick(0, 1, 1, 0, 0, 1));
    directed_q.push_back(tick(1, 0, 0, 0, 0, 1));
    repeat (8) directed_q.push_back(tick(0, 1, 1, 1, 1, 0));
    repeat (4) directed_q.push_back(tick(0, 1, 0, 0, 0, 0));
    directed_q.push_back(tick(1, 1, 1, 1, 1, 1));
    directed_q.push_back(tick(0, 0, 0, 0, 0, 1));
    foreach (directed_q[i]) send_tick(directed_q[i]);
    send_random(150);
    drain_results();

    // zero weight total
    write_reg(REG_BIT_MAP, random_word());
    write_reg(REG_WEIGHTS, '0);
    send_random(200);
    drain_results();

    write_reg(REG_BIT_MAP, '1);
    write_reg(REG_WEIGHTS, '1);
    send_random(200);
    drain_results();

    write_reg(REG_BIT_MAP, '0);
    write_reg(REG_WEIGHTS, 64'h0101_0101);
    send_random(200);
    drain_results();

    // receiver holds off long enough to back up the input
    write_reg(REG_BIT_MAP, random_word());
    write_reg(REG_WEIGHTS, random_word());
    long_hold_req = 1'b1;
    send_random(200);
    drain_results();

    steady_flow = 1'b1;
    write_reg(REG_BIT_MAP, random_word());
    write_reg(REG_WEIGHTS, random_word());
    send_random(200);
    drain_results();
    steady_flow = 1'b0;

    write_reg(REG_BIT_MAP, random_word());
    write_reg(REG_WEIGHTS, 64'hFF00_0000);
    send_random(200);
    drain_results();

    repeat (60) @(posedge clk);
    if (sb.mismatches == 0 && sb.due_outputs.size() == 0) begin
      $display("shift_register_cv_modulator: match");
    end else begin
      $display("shift_register_cv_modulator: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/scm_pkg.sv
sv/scm_regs.sv
sv/scm_ctrl.sv
sv/scm_dp.sv
sv/shift_register_cv_modulator.sv
sv/scm_checker.sv
tb/shift_register_cv_modulator_tb.sv
